>>> sv/btpp_pkg.sv
// ----------------------------------------------------------------------------
// btpp_pkg
// Types, register indexes and policy constants for the battery and thermal
// protection policy block.
// ----------------------------------------------------------------------------
package btpp_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_BATTERY_LOW      = 3'd0;
  localparam logic [2:0] REG_BATTERY_CRITICAL = 3'd1;
  localparam logic [2:0] REG_BATTERY_CUTOFF   = 3'd2;
  localparam logic [2:0] REG_BATTERY_RECOVERY = 3'd3;
  localparam logic [2:0] REG_TEMP_DERATE      = 3'd4;
  localparam logic [2:0] REG_TEMP_SHUTDOWN    = 3'd5;
  localparam logic [2:0] REG_TEMP_RELEASE     = 3'd6;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // register reset values
  localparam logic [15:0]        BATTERY_LOW_RST      = 16'd6400;
  localparam logic [15:0]        BATTERY_CRITICAL_RST = 16'd6200;
  localparam logic [15:0]        BATTERY_CUTOFF_RST   = 16'd6000;
  localparam logic [15:0]        BATTERY_RECOVERY_RST = 16'd6600;
  localparam logic signed [11:0] TEMP_DERATE_RST      = 12'sd600;
  localparam logic signed [11:0] TEMP_SHUTDOWN_RST    = 12'sd650;
  localparam logic signed [11:0] TEMP_RELEASE_RST     = 12'sd550;

  // hold times in ms
  localparam logic [31:0] LOW_HOLD_MS     = 32'd3000;
  localparam logic [31:0] CRIT_HOLD_MS    = 32'd3000;
  localparam logic [31:0] CUTOFF_HOLD_MS  = 32'd1000;
  localparam logic [31:0] RECOVER_HOLD_MS = 32'd5000;

  // fan step thresholds in 0.1 C
  localparam logic signed [11:0] FAN_HI_DC  = 12'sd500;
  localparam logic signed [11:0] FAN_MID_DC = 12'sd450;
  localparam logic signed [11:0] FAN_LO_DC  = 12'sd400;

  // limits and duties in percent
  localparam logic [6:0] LIM_FULL   = 7'd100;
  localparam logic [6:0] LIM_DERATE = 7'd70;
  localparam logic [6:0] LIM_LOW    = 7'd50;
  localparam logic [6:0] LIM_CRIT   = 7'd10;
  localparam logic [6:0] LIM_ADC    = 7'd20;
  localparam logic [6:0] LIM_OFF    = 7'd0;
  localparam logic [6:0] FAN_OFF    = 7'd0;
  localparam logic [6:0] FAN_LO     = 7'd25;
  localparam logic [6:0] FAN_MID    = 7'd60;
  localparam logic [6:0] FAN_MAX    = 7'd100;

  // fault codes
  localparam logic [2:0] FAULT_NONE     = 3'd0;
  localparam logic [2:0] FAULT_LOW      = 3'd1;
  localparam logic [2:0] FAULT_CRIT     = 3'd2;
  localparam logic [2:0] FAULT_OVERTEMP = 3'd3;
  localparam logic [2:0] FAULT_SENSOR   = 3'd4;
  localparam logic [2:0] FAULT_ADC      = 3'd5;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic [15:0]        battery_mv;
    logic               battery_ok;
    logic signed [11:0] temp_dc;
    logic               temp_ok;
    logic               manual_fan;
  } sample_t;

  typedef struct packed {
    logic [6:0] light_limit_pct;
    logic [6:0] fan_pct;
    logic       light_permitted;
    logic       low_batt_flag;
    logic       crit_batt_flag;
    logic       overtemp_flag;
    logic       cutoff_flag;
    logic [2:0] fault_code;
  } result_t;

  function automatic logic [6:0] min7(input logic [6:0] a, input logic [6:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

>>> sv/battery_thermal_protection_policy.sv
// ----------------------------------------------------------------------------
// battery_thermal_protection_policy
// Per-sample battery and thermal protection: duration latches for low,
// critical and cutoff battery, recovery clear, overtemp hysteresis, light
// limit, fan duty and fault code.
// ----------------------------------------------------------------------------
// Usage:
//   sample / sample_valid / sample_ready carry one evaluation request: time,
//   battery mV with valid bit, temperature in 0.1 C with valid bit, manual fan.
//   result / result_valid / result_ready return one result per request.
//   cfg_we / cfg_index / cfg_wdata write the seven thresholds; an index past
//   the list is ignored. Write only while no request is in flight.
// Timing:
//   A request is registered, evaluated in the input register against the
//   tracker and latch state, and the result register loads when it advances:
//   one request per cycle while result_ready holds high. The tracker state
//   is updated at the same edge the result register loads.
// Reset (rst, synchronous): trackers and latches clear, thresholds return to
//   their defaults, both pipeline slots empty.
// Stall: when result_ready is low the result holds; one more request can sit
//   in the input register, after which sample_ready drops.
// ----------------------------------------------------------------------------
module battery_thermal_protection_policy (
  input  logic                                clk,
  input  logic                                rst,
  input  btpp_pkg::sample_t                   sample,
  input  logic                                sample_valid,
  output logic                                sample_ready,
  output btpp_pkg::result_t                   result,
  output logic                                result_valid,
  input  logic                                result_ready,
  input  logic                                cfg_we,
  input  logic [btpp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [btpp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import btpp_pkg::*;

  // thresholds
  logic [15:0]        battery_low_mv;
  logic [15:0]        battery_critical_mv;
  logic [15:0]        battery_cutoff_mv;
  logic [15:0]        battery_recovery_mv;
  logic signed [11:0] temp_derate_dc;
  logic signed [11:0] temp_shutdown_dc;
  logic signed [11:0] temp_release_dc;

  // tracker and latch state
  logic        low_timing, crit_timing, recover_timing, cutoff_timing;
  logic [31:0] low_start_ms, crit_start_ms, recover_start_ms, cutoff_start_ms;
  logic        low_latched, crit_latched, overtemp_latched, cutoff_latched;

  logic        low_timing_next, crit_timing_next, recover_timing_next, cutoff_timing_next;
  logic [31:0] low_start_ms_next, crit_start_ms_next;
  logic [31:0] recover_start_ms_next, cutoff_start_ms_next;
  logic        low_latched_next, crit_latched_next;
  logic        overtemp_latched_next, cutoff_latched_next;

  // pipeline
  sample_t s1;
  logic    s1_valid;
  logic    adv;
  result_t result_next;

  logic cond_low, cond_crit, cond_rec, cond_cut;
  logic held_low, held_crit, held_rec, held_cut;

  assign adv          = s1_valid && (!result_valid || result_ready);
  assign sample_ready = !s1_valid || adv;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      battery_low_mv      <= BATTERY_LOW_RST;
      battery_critical_mv <= BATTERY_CRITICAL_RST;
      battery_cutoff_mv   <= BATTERY_CUTOFF_RST;
      battery_recovery_mv <= BATTERY_RECOVERY_RST;
      temp_derate_dc      <= TEMP_DERATE_RST;
      temp_shutdown_dc    <= TEMP_SHUTDOWN_RST;
      temp_release_dc     <= TEMP_RELEASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BATTERY_LOW:      battery_low_mv      <= cfg_wdata;
        REG_BATTERY_CRITICAL: battery_critical_mv <= cfg_wdata;
        REG_BATTERY_CUTOFF:   battery_cutoff_mv   <= cfg_wdata;
        REG_BATTERY_RECOVERY: battery_recovery_mv <= cfg_wdata;
        REG_TEMP_DERATE:      temp_derate_dc      <= cfg_wdata[11:0];
        REG_TEMP_SHUTDOWN:    temp_shutdown_dc    <= cfg_wdata[11:0];
        REG_TEMP_RELEASE:     temp_release_dc     <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // duration trackers; a fresh start gives zero elapsed, so held needs timing
  always_comb begin
    cond_low  = s1.battery_ok && (s1.battery_mv < battery_low_mv);
    cond_crit = s1.battery_ok && (s1.battery_mv < battery_critical_mv);
    cond_rec  = s1.battery_ok && (s1.battery_mv > battery_recovery_mv);
    cond_cut  = s1.battery_ok && (s1.battery_mv < battery_cutoff_mv);

    held_low  = cond_low  && low_timing     && ((s1.now_ms - low_start_ms) >= LOW_HOLD_MS);
    held_crit = cond_crit && crit_timing    && ((s1.now_ms - crit_start_ms) >= CRIT_HOLD_MS);
    held_rec  = cond_rec  && recover_timing &&
                ((s1.now_ms - recover_start_ms) >= RECOVER_HOLD_MS);
    held_cut  = cond_cut  && cutoff_timing  &&
                ((s1.now_ms - cutoff_start_ms) >= CUTOFF_HOLD_MS);

    low_timing_next     = cond_low;
    crit_timing_next    = cond_crit;
    recover_timing_next = cond_rec;
    cutoff_timing_next  = cond_cut;

    low_start_ms_next     = (cond_low  && !low_timing)     ? s1.now_ms : low_start_ms;
    crit_start_ms_next    = (cond_crit && !crit_timing)    ? s1.now_ms : crit_start_ms;
    recover_start_ms_next = (cond_rec  && !recover_timing) ? s1.now_ms : recover_start_ms;
    cutoff_start_ms_next  = (cond_cut  && !cutoff_timing)  ? s1.now_ms : cutoff_start_ms;

    // recovery clears after low/crit set, cutoff set wins over the clear
    low_latched_next    = (low_latched  || held_low)  && !held_rec;
    crit_latched_next   = (crit_latched || held_crit) && !held_rec;
    cutoff_latched_next = (cutoff_latched && !held_rec) || held_cut;

    priority if (s1.temp_ok && (s1.temp_dc >= temp_shutdown_dc)) begin
      overtemp_latched_next = 1'b1;
    end else if (s1.temp_ok && (s1.temp_dc < temp_release_dc)) begin
      overtemp_latched_next = 1'b0;
    end else begin
      overtemp_latched_next = overtemp_latched;
    end
  end

  // result selection; later checks override earlier ones, but most light limits only lower the current limit
  always_comb begin
    result_next = '0;

    priority if (!s1.temp_ok || (s1.temp_dc >= FAN_HI_DC)) begin
      result_next.fan_pct = FAN_MAX;
    end else if (s1.temp_dc >= FAN_MID_DC) begin
      result_next.fan_pct = FAN_MID;
    end else if (s1.temp_dc >= FAN_LO_DC) begin
      result_next.fan_pct = FAN_LO;
    end else begin
      result_next.fan_pct = FAN_OFF;
    end

    result_next.light_limit_pct = LIM_FULL;
    result_next.light_permitted = 1'b1;
    result_next.fault_code      = FAULT_NONE;

    if (low_latched_next) begin
      result_next.light_limit_pct = min7(result_next.light_limit_pct, LIM_LOW);
      result_next.fault_code      = FAULT_LOW;
    end
    if (crit_latched_next) begin
      result_next.light_limit_pct = min7(result_next.light_limit_pct, LIM_CRIT);
      result_next.fault_code      = FAULT_CRIT;
    end
    if (s1.temp_ok && (s1.temp_dc >= temp_derate_dc)) begin
      result_next.light_limit_pct = min7(result_next.light_limit_pct, LIM_DERATE);
    end
    if (overtemp_latched_next) begin
      result_next.light_limit_pct = LIM_OFF;
      result_next.light_permitted = 1'b0;
      result_next.fault_code      = FAULT_OVERTEMP;
    end
    if (!s1.battery_ok) begin
      result_next.light_limit_pct = min7(result_next.light_limit_pct, LIM_ADC);
      result_next.fault_code      = FAULT_ADC;
    end
    if (!s1.temp_ok) begin
      result_next.light_limit_pct = LIM_OFF;
      result_next.fan_pct         = FAN_MAX;
      result_next.light_permitted = 1'b0;
      result_next.fault_code      = FAULT_SENSOR;
    end
    if (cutoff_latched_next) begin
      result_next.light_limit_pct = LIM_OFF;
      result_next.light_permitted = 1'b0;
      result_next.fault_code      = FAULT_CRIT;
    end
    if (s1.manual_fan) begin
      result_next.fan_pct = FAN_MAX;
    end

    result_next.low_batt_flag  = low_latched_next;
    result_next.crit_batt_flag = crit_latched_next;
    result_next.overtemp_flag  = overtemp_latched_next;
    result_next.cutoff_flag    = cutoff_latched_next;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_ready) begin
      s1_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_ready && sample_valid) begin
      s1 <= sample;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= result_next;
    end
  end

  // state update once per evaluated request
  always_ff @(posedge clk) begin
    if (rst) begin
      low_timing       <= 1'b0;
      crit_timing      <= 1'b0;
      recover_timing   <= 1'b0;
      cutoff_timing    <= 1'b0;
      low_start_ms     <= '0;
      crit_start_ms    <= '0;
      recover_start_ms <= '0;
      cutoff_start_ms  <= '0;
      low_latched      <= 1'b0;
      crit_latched     <= 1'b0;
      overtemp_latched <= 1'b0;
      cutoff_latched   <= 1'b0;
    end else if (adv) begin
      low_timing       <= low_timing_next;
      crit_timing      <= crit_timing_next;
      recover_timing   <= recover_timing_next;
      cutoff_timing    <= cutoff_timing_next;
      low_start_ms     <= low_start_ms_next;
      crit_start_ms    <= crit_start_ms_next;
      recover_start_ms <= recover_start_ms_next;
      cutoff_start_ms  <= cutoff_start_ms_next;
      low_latched      <= low_latched_next;
      crit_latched     <= crit_latched_next;
      overtemp_latched <= overtemp_latched_next;
      cutoff_latched   <= cutoff_latched_next;
    end
  end

  // checks
  a_recovery_clears: assert property (@(posedge clk) disable iff (rst)
    adv && held_rec |=> !low_latched && !crit_latched)
    else $error("recovery did not clear battery latches");

  a_adc_error_drops_trackers: assert property (@(posedge clk) disable iff (rst)
    adv && !s1.battery_ok |=> !low_timing && !crit_timing && !recover_timing && !cutoff_timing)
    else $error("invalid battery reading left a tracker running");

  a_flags_track_state: assert property (@(posedge clk) disable iff (rst)
    adv |=> result.low_batt_flag == low_latched && result.crit_batt_flag == crit_latched &&
            result.overtemp_flag == overtemp_latched && result.cutoff_flag == cutoff_latched)
    else $error("result flags differ from latch state");

  a_cutoff_forces_off: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.cutoff_flag |-> !result.light_permitted &&
                                           result.light_limit_pct == LIM_OFF)
    else $error("cutoff latched but light allowed");

  a_stalled_slot_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |=> s1_valid && $stable(s1))
    else $error("input register lost a stalled request");

endmodule
